// File: sv/lcpie_pkg.sv
// Shared types, widths and register codes for the LCP interval enumerator.
package lcpie_pkg;

  localparam int TEXT_SIZE_DEF     = 16777216;
  localparam int STACK_ENTRIES_DEF = 64;

  localparam int POS_W  = 24;
  localparam int LEN_W  = 6;
  localparam int FREQ_W = 25;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W  = ADDR_W - 2;

  localparam logic [REG_W-1:0] REG_MIN_LENGTH    = REG_W'(0);
  localparam logic [REG_W-1:0] REG_MAX_LENGTH    = REG_W'(1);
  localparam logic [REG_W-1:0] REG_MIN_FREQUENCY = REG_W'(2);

  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST    = LEN_W'(2);
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST    = LEN_W'(62);
  localparam logic [LEN_W-1:0]  DEPTH_CAP         = LEN_W'(63);
  localparam logic [FREQ_W-1:0] MIN_FREQUENCY_RST = FREQ_W'(50);
  localparam logic [FREQ_W-1:0] FREQ_SAT          = {FREQ_W{1'b1}};

  typedef struct packed {
    logic [LEN_W-1:0]  min_length;
    logic [LEN_W-1:0]  max_length;
    logic [FREQ_W-1:0] min_frequency;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  left_bound;
    logic [LEN_W-1:0]  depth;
    logic [FREQ_W-1:0] child_sum;
  } stk_entry_t;

  typedef struct packed {
    logic [POS_W-1:0]  left_bound;
    logic [POS_W-1:0]  right_bound;
    logic [LEN_W-1:0]  depth;
    logic [FREQ_W-1:0] frequency;
    logic [FREQ_W-1:0] exclusive_frequency;
    logic              is_summary;
    logic [FREQ_W-1:0] candidate_total;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic pop;
    logic load;
    logic push;
    logic summary;
    logic finish;
    logic drain;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sp_nonzero;
    logic v_lt_top;
    logic pos_zero;
    logic last;
    logic slot_ok;
  } dp_status_t;

endpackage

// File: sv/lcpie_ctrl.sv
// Sequencer for the LCP interval enumerator: walks pops, push, drain and flush.
module lcpie_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcpie_pkg::dp_status_t  status,
  output lcpie_pkg::ctrl_cmd_t   cmd
);
  import lcpie_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_START = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_PUSH  = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    drain_nxt   = drain_r;
    cmd         = '0;
    cmd.drain   = drain_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          drain_nxt  = 1'b0;
          state_nxt  = S_START;
        end
      end
      S_START: begin
        if (!status.pos_zero) begin
          state_nxt = S_CMP;
        end else if (status.last) begin
          drain_nxt = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        if (status.sp_nonzero && (drain_r || status.v_lt_top)) begin
          state_nxt = S_POP;
        end else if (drain_r) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_POP: begin
        if (status.slot_ok) begin
          cmd.pop   = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_CMP;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (status.last) begin
          drain_nxt = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SUM: begin
        if (status.slot_ok) begin
          cmd.summary = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (status.slot_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// File: sv/lcpie_datapath.sv
// Interval stack, position and count registers, and the result word staging.
module lcpie_datapath #(
  parameter int TEXT_SIZE     = lcpie_pkg::TEXT_SIZE_DEF,
  parameter int STACK_ENTRIES = lcpie_pkg::STACK_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcpie_pkg::cfg_t               cfg,
  input  lcpie_pkg::ctrl_cmd_t          cmd,
  output lcpie_pkg::dp_status_t         status,
  input  logic [lcpie_pkg::POS_W-1:0]   in_lcp_value,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcpie_pkg::POS_W-1:0]   out_left_bound,
  output logic [lcpie_pkg::POS_W-1:0]   out_right_bound,
  output logic [lcpie_pkg::LEN_W-1:0]   out_depth,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_frequency,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_exclusive_frequency,
  output logic                          out_is_summary,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_candidate_total,
  output logic                          out_end_of_run
);
  import lcpie_pkg::*;

  localparam int SP_W  = $clog2(STACK_ENTRIES + 1);
  localparam int IDX_W = $clog2(STACK_ENTRIES);
  localparam logic [SP_W-1:0]  SP_FULL = SP_W'(STACK_ENTRIES);
  localparam logic [POS_W-1:0] POS_LIM =
    (TEXT_SIZE > (1 << POS_W)) ? {POS_W{1'b1}} : POS_W'(TEXT_SIZE - 1);
  localparam stk_entry_t ROOT = '{left_bound: '0, depth: '0, child_sum: '0};

  stk_entry_t stack_mem [STACK_ENTRIES];
  stk_entry_t rd_r;
  stk_entry_t top_r, top_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FREQ_W-1:0] emitted_r, emitted_nxt;
  logic [LEN_W-1:0]  lcp_r, lcp_nxt;
  logic              last_r, last_nxt;
  logic [POS_W-1:0]  lb_save_r, lb_save_nxt;
  logic [FREQ_W-1:0] f_r, f_nxt;
  rec_t              pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  rec_t              out_r, out_nxt;
  logic              out_eor_r, out_eor_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [LEN_W-1:0]  clip;
  logic [LEN_W-1:0]  lcp_clip;
  logic [POS_W-1:0]  rb;
  logic [FREQ_W-1:0] rb_inc;
  logic [FREQ_W-1:0] lb_ext;
  logic [FREQ_W-1:0] freq;
  logic [FREQ_W-1:0] excl;
  logic [LEN_W-1:0]  len_lo;
  logic              report;
  logic [FREQ_W:0]   sum_wide;
  logic [FREQ_W-1:0] sum_sat;
  logic              push_ok;
  logic              out_free;
  logic              load_out;
  logic [SP_W-1:0]   sp_dec;
  logic [SP_W-1:0]   sp_dec2;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  rec_t              cand;
  rec_t              summ;

  assign clip     = (cfg.max_length >= DEPTH_CAP) ? DEPTH_CAP : LEN_W'(cfg.max_length + 1'b1);
  assign lcp_clip = (in_lcp_value > POS_W'(clip)) ? clip : in_lcp_value[LEN_W-1:0];

  assign rb       = cmd.drain ? pos_r : POS_W'(pos_r - 1'b1);
  assign rb_inc   = {1'b0, rb} + FREQ_W'(1);
  assign lb_ext   = {1'b0, top_r.left_bound};
  assign freq     = (rb_inc >= lb_ext) ? FREQ_W'(rb_inc - lb_ext) : '0;
  assign excl     = (freq > top_r.child_sum) ? FREQ_W'(freq - top_r.child_sum) : '0;
  assign len_lo   = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
  assign report   = (top_r.depth >= len_lo) && (top_r.depth <= cfg.max_length) &&
                    (freq >= cfg.min_frequency);

  assign sum_wide = {1'b0, rd_r.child_sum} + {1'b0, f_r};
  assign sum_sat  = sum_wide[FREQ_W] ? FREQ_SAT : sum_wide[FREQ_W-1:0];

  assign push_ok  = ((sp_r == '0) || (lcp_r > top_r.depth)) && (sp_r < SP_FULL);
  assign out_free = !out_valid_r || out_ready;

  assign sp_dec   = sp_r - SP_W'(1);
  assign sp_dec2  = sp_r - SP_W'(2);
  assign wr_idx   = sp_dec[IDX_W-1:0];
  assign rd_idx   = sp_dec2[IDX_W-1:0];

  assign cand = '{left_bound: top_r.left_bound, right_bound: rb, depth: top_r.depth,
                  frequency: freq, exclusive_frequency: excl, is_summary: 1'b0,
                  candidate_total: '0};
  assign summ = '{left_bound: '0, right_bound: '0, depth: '0, frequency: '0,
                  exclusive_frequency: '0, is_summary: 1'b1, candidate_total: emitted_r};

  always_comb begin
    top_nxt        = top_r;
    sp_nxt         = sp_r;
    pos_nxt        = pos_r;
    emitted_nxt    = emitted_r;
    lcp_nxt        = lcp_r;
    last_nxt       = last_r;
    lb_save_nxt    = lb_save_r;
    f_nxt          = f_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_eor_nxt    = out_eor_r;
    load_out       = 1'b0;

    if (cmd.accept) begin
      lcp_nxt     = lcp_clip;
      last_nxt    = in_last_item;
      lb_save_nxt = pos_r;
    end

    if (cmd.pop) begin
      sp_nxt      = sp_dec;
      f_nxt       = freq;
      lb_save_nxt = top_r.left_bound;
      if (report) begin
        pend_nxt       = cand;
        pend_valid_nxt = 1'b1;
        if (emitted_r != FREQ_SAT) begin
          emitted_nxt = emitted_r + FREQ_W'(1);
        end
        if (pend_valid_r) begin
          load_out    = 1'b1;
          out_nxt     = pend_r;
          out_eor_nxt = 1'b0;
        end
      end
    end

    if (cmd.load && (sp_r != '0)) begin
      top_nxt = '{left_bound: rd_r.left_bound, depth: rd_r.depth, child_sum: sum_sat};
    end

    if (cmd.push && push_ok) begin
      top_nxt = '{left_bound: lb_save_r, depth: lcp_r, child_sum: '0};
      sp_nxt  = sp_r + SP_W'(1);
    end

    if (cmd.summary) begin
      pend_nxt       = summ;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        load_out    = 1'b1;
        out_nxt     = pend_r;
        out_eor_nxt = 1'b0;
      end
      // start a new run
      sp_nxt      = SP_W'(1);
      top_nxt     = ROOT;
      pos_nxt     = '0;
      emitted_nxt = '0;
    end

    if (cmd.finish) begin
      if (pend_valid_r) begin
        load_out    = 1'b1;
        out_nxt     = pend_r;
        out_eor_nxt = 1'b1;
      end
      pend_valid_nxt = 1'b0;
      if (!last_r && (pos_r < POS_LIM)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= ROOT;
      sp_r         <= SP_W'(1);
      pos_r        <= '0;
      emitted_r    <= '0;
      last_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      top_r        <= top_nxt;
      sp_r         <= sp_nxt;
      pos_r        <= pos_nxt;
      emitted_r    <= emitted_nxt;
      last_r       <= last_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcp_r     <= lcp_nxt;
    lb_save_r <= lb_save_nxt;
    f_r       <= f_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    out_eor_r <= out_eor_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok && (sp_r != '0)) begin
      stack_mem[wr_idx] <= top_r;
    end
    rd_r <= stack_mem[rd_idx];
  end

  assign status.sp_nonzero = (sp_r != '0);
  assign status.v_lt_top   = (lcp_r < top_r.depth);
  assign status.pos_zero   = (pos_r == '0);
  assign status.last       = last_r;
  assign status.slot_ok    = !pend_valid_r || out_free;

  assign out_valid               = out_valid_r;
  assign out_left_bound          = out_r.left_bound;
  assign out_right_bound         = out_r.right_bound;
  assign out_depth               = out_r.depth;
  assign out_frequency           = out_r.frequency;
  assign out_exclusive_frequency = out_r.exclusive_frequency;
  assign out_is_summary          = out_r.is_summary;
  assign out_candidate_total     = out_r.candidate_total;
  assign out_end_of_run          = out_eor_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_FULL)
    else $error("stack pointer beyond stack size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("result word overwritten before it was taken");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (sp_r != '0))
    else $error("pop on empty stack");

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !pend_valid_r)
    else $error("staged result left over from previous word");

endmodule

// File: sv/lcp_interval_enumerator.sv
// Top level of the LCP interval enumerator: register file, sequencer and datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in_      | in_valid / in_ready  | in_lcp_value, in_last_item
//  out_     | out_valid/out_ready  | bounds, depth, frequencies, summary, end_of_run
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always high)
//
//  An input word pops the stack once per interval closed (one stack memory read
//  and its registered data per pop) before its push; a last word then drains the stack.
//  The first word of a run is not pushed; if it is last, every entry is drained.
//  rst_n is synchronous: the stack holds the root only, counters clear, no sweep.
//  A stalled output holds the sequencer once one further result is staged.
module lcp_interval_enumerator #(
  parameter int TEXT_SIZE     = lcpie_pkg::TEXT_SIZE_DEF,
  parameter int STACK_ENTRIES = lcpie_pkg::STACK_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcpie_pkg::POS_W-1:0]   in_lcp_value,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcpie_pkg::POS_W-1:0]   out_left_bound,
  output logic [lcpie_pkg::POS_W-1:0]   out_right_bound,
  output logic [lcpie_pkg::LEN_W-1:0]   out_depth,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_frequency,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_exclusive_frequency,
  output logic                          out_is_summary,
  output logic [lcpie_pkg::FREQ_W-1:0]  out_candidate_total,
  output logic                          out_end_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcpie_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcpie_pkg::DATA_W-1:0]  pwdata,
  output logic [lcpie_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import lcpie_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [REG_W-1:0] reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_LENGTH:    cfg_nxt.min_length    = pwdata[LEN_W-1:0];
        REG_MAX_LENGTH:    cfg_nxt.max_length    = pwdata[LEN_W-1:0];
        REG_MIN_FREQUENCY: cfg_nxt.min_frequency = pwdata[FREQ_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_LENGTH:    prdata = DATA_W'(cfg_r.min_length);
      REG_MAX_LENGTH:    prdata = DATA_W'(cfg_r.max_length);
      REG_MIN_FREQUENCY: prdata = DATA_W'(cfg_r.min_frequency);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{min_length: MIN_LENGTH_RST, max_length: MAX_LENGTH_RST,
                 min_frequency: MIN_FREQUENCY_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcpie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lcpie_datapath #(
    .TEXT_SIZE     (TEXT_SIZE),
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .cmd                     (cmd),
    .status                  (status),
    .in_lcp_value            (in_lcp_value),
    .in_last_item            (in_last_item),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_left_bound          (out_left_bound),
    .out_right_bound         (out_right_bound),
    .out_depth               (out_depth),
    .out_frequency           (out_frequency),
    .out_exclusive_frequency (out_exclusive_frequency),
    .out_is_summary          (out_is_summary),
    .out_candidate_total     (out_candidate_total),
    .out_end_of_run          (out_end_of_run)
  );

endmodule
